FILE: design/linear_regression_correlation_macros.svh
// assertion macros shared by the line fit block
`ifndef LINEAR_REGRESSION_CORRELATION_MACROS_SVH
`define LINEAR_REGRESSION_CORRELATION_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define LRC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define LRC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lrc_pkg.sv
// types, widths and operation codes of the line fit block
`timescale 1ns / 1ps

package lrc_pkg;

    // sample and count widths
    localparam int SAMPLE_W   = 16;
    localparam int COUNT_LOG2 = 16;
    localparam int CNT_W      = COUNT_LOG2 + 1;

    // running sum widths
    localparam int SUM_W = SAMPLE_W + COUNT_LOG2 + 1;
    localparam int SQ_W  = 2 * SAMPLE_W + COUNT_LOG2 - 1;
    localparam int XY_W  = 2 * SAMPLE_W + COUNT_LOG2;

    // width of the shared arithmetic, holds the product of two determinants
    localparam int WIDE_W     = 4 * (SAMPLE_W + COUNT_LOG2);
    localparam int ROOT_W     = WIDE_W / 2;
    localparam int DIV_CNT_W  = $clog2(WIDE_W + 1);
    localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);

    // result formats
    localparam int Q_W       = 48;
    localparam int CORR_W    = 16;
    localparam int FRAC_Q    = 16;
    localparam int FRAC_CORR = 14;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x_value;
        logic signed [SAMPLE_W-1:0] y_value;
        logic                       last;
    } sample_t;

    typedef struct packed {
        logic signed [Q_W-1:0]    intercept;
        logic signed [Q_W-1:0]    slope;
        logic signed [CORR_W-1:0] correlation;
        logic                     degenerate;
        logic                     corr_undefined;
    } result_t;

    // multiplications in issue order, pairs whose products are subtracted
    typedef enum logic [3:0] {
        MUL_N_SXX  = 4'd0,
        MUL_SX_SX  = 4'd1,
        MUL_SXX_SY = 4'd2,
        MUL_SX_SXY = 4'd3,
        MUL_N_SXY  = 4'd4,
        MUL_SX_SY  = 4'd5,
        MUL_N_SYY  = 4'd6,
        MUL_SY_SY  = 4'd7,
        MUL_DET_VY = 4'd8
    } mul_op_t;

    typedef enum logic [1:0] {
        DIV_INTERCEPT = 2'd0,
        DIV_SLOPE     = 2'd1,
        DIV_CORR      = 2'd2
    } div_op_t;

    // controller to datapath
    typedef struct packed {
        logic    acc_en;
        logic    acc_clear;
        logic    res_clear;
        logic    mul_start;
        mul_op_t mul_sel;
        logic    mul_commit;
        logic    div_start;
        div_op_t div_sel;
        logic    div_commit;
        logic    root_start;
        logic    set_degen;
        logic    set_undef;
        logic    out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mul_busy;
        logic div_busy;
        logic root_busy;
        logic det_zero;
        logic vy_zero;
        logic root_zero;
        logic out_free;
    } status_t;

endpackage

FILE: design/lrc_dp.sv
// datapath: running sums, shift-add multiplier, divider, square root, result register
`timescale 1ns / 1ps

module lrc_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  lrc_pkg::sample_t sample,
    input  lrc_pkg::cmd_t    cmd,
    output lrc_pkg::status_t status,
    output logic             result_valid,
    input  logic             result_ready,
    output lrc_pkg::result_t result
);

    localparam int W    = lrc_pkg::WIDE_W;
    localparam int RW   = lrc_pkg::ROOT_W + 2;
    localparam int QW   = lrc_pkg::Q_W;
    localparam int CW   = lrc_pkg::CORR_W;

    localparam logic [W-1:0] Q_POS_MAX = {{(W-QW+1){1'b0}}, {(QW-1){1'b1}}};
    localparam logic [W-1:0] Q_NEG_MAG = Q_POS_MAX + W'(1);
    localparam logic [W-1:0] CORR_ONE  = W'(1) << lrc_pkg::FRAC_CORR;
    localparam logic [QW-1:0] Q_MAX    = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] Q_MIN    = {1'b1, {(QW-1){1'b0}}};

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
        mag = v[W-1] ? W'(-v) : W'(v);
    endfunction

    // running sums
    logic [lrc_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [lrc_pkg::SUM_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [lrc_pkg::SQ_W-1:0]         sxx_reg, sxx_next, syy_reg, syy_next;
    logic signed [lrc_pkg::XY_W-1:0]  sxy_reg, sxy_next;
    logic signed [2*lrc_pkg::SAMPLE_W-1:0] xx, xy, yy;

    assign xx = sample.x_value * sample.x_value;
    assign xy = sample.x_value * sample.y_value;
    assign yy = sample.y_value * sample.y_value;

    // clear the sums, or add the item unless the count is full
    always_comb
    begin
        cnt_next = cnt_reg;
        sx_next  = sx_reg;
        sy_next  = sy_reg;
        sxx_next = sxx_reg;
        sxy_next = sxy_reg;
        syy_next = syy_reg;
        if (cmd.acc_clear)
        begin
            cnt_next = '0;
            sx_next  = '0;
            sy_next  = '0;
            sxx_next = '0;
            sxy_next = '0;
            syy_next = '0;
        end
        else if (cmd.acc_en && !cnt_reg[lrc_pkg::CNT_W-1])
        begin
            cnt_next = cnt_reg + lrc_pkg::CNT_W'(1);
            sx_next  = sx_reg + lrc_pkg::SUM_W'(sample.x_value);
            sy_next  = sy_reg + lrc_pkg::SUM_W'(sample.y_value);
            sxx_next = sxx_reg + lrc_pkg::SQ_W'($unsigned(xx));
            sxy_next = sxy_reg + lrc_pkg::XY_W'(xy);
            syy_next = syy_reg + lrc_pkg::SQ_W'($unsigned(yy));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxx_reg <= '0;
            sxy_reg <= '0;
            syy_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            sxx_reg <= sxx_next;
            sxy_reg <= sxy_next;
            syy_reg <= syy_next;
        end
    end

    // sums widened for the shared arithmetic
    logic signed [W-1:0] n_s, sx_s, sy_s, sxx_s, sxy_s, syy_s;
    assign n_s   = W'(cnt_reg);
    assign sx_s  = W'(sx_reg);
    assign sy_s  = W'(sy_reg);
    assign sxx_s = W'(sxx_reg);
    assign sxy_s = W'(sxy_reg);
    assign syy_s = W'(syy_reg);

    // intermediate terms
    logic signed [W-1:0] tmp_reg, tmp_next, det_reg, det_next, bnum_reg, bnum_next;
    logic signed [W-1:0] anum_reg, anum_next, vy_reg, vy_next;

    // multiplier operand selection, shorter operand second
    logic signed [W-1:0] op_a, op_b;
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (cmd.mul_sel)
            lrc_pkg::MUL_N_SXX:  begin op_a = sxx_s;   op_b = n_s;    end
            lrc_pkg::MUL_SX_SX:  begin op_a = sx_s;    op_b = sx_s;   end
            lrc_pkg::MUL_SXX_SY: begin op_a = sxx_s;   op_b = sy_s;   end
            lrc_pkg::MUL_SX_SXY: begin op_a = sxy_s;   op_b = sx_s;   end
            lrc_pkg::MUL_N_SXY:  begin op_a = sxy_s;   op_b = n_s;    end
            lrc_pkg::MUL_SX_SY:  begin op_a = sx_s;    op_b = sy_s;   end
            lrc_pkg::MUL_N_SYY:  begin op_a = syy_s;   op_b = n_s;    end
            lrc_pkg::MUL_SY_SY:  begin op_a = sy_s;    op_b = sy_s;   end
            lrc_pkg::MUL_DET_VY: begin op_a = det_reg; op_b = vy_reg; end
            default:             begin op_a = '0;      op_b = '0;     end
        endcase
    end

    // shift-add multiplier on magnitudes, stops when the multiplier runs out
    logic [W-1:0]     ma_reg, ma_next, mb_reg, mb_next, prod_reg, prod_next;
    logic             mneg_reg, mneg_next, mbusy_reg, mbusy_next;
    lrc_pkg::mul_op_t msel_reg, msel_next;
    logic signed [W-1:0] prod_s;

    always_comb
    begin
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        prod_next  = prod_reg;
        mneg_next  = mneg_reg;
        mbusy_next = mbusy_reg;
        msel_next  = msel_reg;
        if (cmd.mul_start)
        begin
            ma_next    = mag(op_a);
            mb_next    = mag(op_b);
            prod_next  = '0;
            mneg_next  = op_a[W-1] ^ op_b[W-1];
            mbusy_next = 1'b1;
            msel_next  = cmd.mul_sel;
        end
        else if (mbusy_reg)
        begin
            if (mb_reg == '0)
            begin
                mbusy_next = 1'b0;
            end
            else
            begin
                if (mb_reg[0])
                begin
                    prod_next = prod_reg + ma_reg;
                end
                ma_next = {ma_reg[W-2:0], 1'b0};
                mb_next = {1'b0, mb_reg[W-1:1]};
            end
        end
    end

    assign prod_s = mneg_reg ? -$signed(prod_reg) : $signed(prod_reg);

    // store a finished product, second of a pair is subtracted from the first
    always_comb
    begin
        tmp_next  = tmp_reg;
        det_next  = det_reg;
        bnum_next = bnum_reg;
        anum_next = anum_reg;
        vy_next   = vy_reg;
        if (cmd.mul_commit)
        begin
            unique case (msel_reg)
                lrc_pkg::MUL_N_SXX,
                lrc_pkg::MUL_SXX_SY,
                lrc_pkg::MUL_N_SXY,
                lrc_pkg::MUL_N_SYY,
                lrc_pkg::MUL_DET_VY: tmp_next  = prod_s;
                lrc_pkg::MUL_SX_SX:  det_next  = tmp_reg - prod_s;
                lrc_pkg::MUL_SX_SXY: bnum_next = tmp_reg - prod_s;
                lrc_pkg::MUL_SX_SY:  anum_next = tmp_reg - prod_s;
                lrc_pkg::MUL_SY_SY:  vy_next   = tmp_reg - prod_s;
                default:             tmp_next  = tmp_reg;
            endcase
        end
    end

    // floor square root, two radicand bits a step
    logic [W-1:0]                   rsrc_reg, rsrc_next;
    logic [RW-1:0]                  rrem_reg, rrem_next, rrem_sh, rtrial;
    logic [lrc_pkg::ROOT_W-1:0]     root_reg, root_next;
    logic [lrc_pkg::ROOT_CNT_W-1:0] rcnt_reg, rcnt_next;
    logic                           rge;

    assign rrem_sh = {rrem_reg[RW-3:0], rsrc_reg[W-1:W-2]};
    assign rtrial  = {root_reg, 2'b01};
    assign rge     = (rrem_sh >= rtrial);

    always_comb
    begin
        rsrc_next = rsrc_reg;
        rrem_next = rrem_reg;
        root_next = root_reg;
        rcnt_next = rcnt_reg;
        if (cmd.root_start)
        begin
            rsrc_next = W'(tmp_reg);
            rrem_next = '0;
            root_next = '0;
            rcnt_next = lrc_pkg::ROOT_CNT_W'(lrc_pkg::ROOT_W);
        end
        else if (rcnt_reg != '0)
        begin
            rsrc_next = {rsrc_reg[W-3:0], 2'b00};
            rrem_next = rge ? rrem_sh - rtrial : rrem_sh;
            root_next = {root_reg[lrc_pkg::ROOT_W-2:0], rge};
            rcnt_next = rcnt_reg - lrc_pkg::ROOT_CNT_W'(1);
        end
    end

    // divider operands: scaled numerator magnitude over a positive divisor
    logic [W-1:0] div_dvd, div_dsor;
    logic         div_neg;
    always_comb
    begin
        div_dvd  = '0;
        div_dsor = '0;
        div_neg  = 1'b0;
        unique case (cmd.div_sel)
            lrc_pkg::DIV_INTERCEPT:
            begin
                div_dvd  = mag(bnum_reg) << lrc_pkg::FRAC_Q;
                div_dsor = mag(det_reg);
                div_neg  = bnum_reg[W-1];
            end
            lrc_pkg::DIV_SLOPE:
            begin
                div_dvd  = mag(anum_reg) << lrc_pkg::FRAC_Q;
                div_dsor = mag(det_reg);
                div_neg  = anum_reg[W-1];
            end
            lrc_pkg::DIV_CORR:
            begin
                div_dvd  = mag(anum_reg) << lrc_pkg::FRAC_CORR;
                div_dsor = W'(root_reg);
                div_neg  = anum_reg[W-1];
            end
            default:
            begin
                div_dvd  = '0;
                div_dsor = '0;
                div_neg  = 1'b0;
            end
        endcase
    end

    // restoring divider, one quotient bit a step
    logic [W-1:0]                  dq_reg, dq_next, drem_reg, drem_next, dsor_reg, dsor_next;
    logic [W:0]                    drem_sh;
    logic                          dneg_reg, dneg_next, dge;
    logic [lrc_pkg::DIV_CNT_W-1:0] dcnt_reg, dcnt_next;
    lrc_pkg::div_op_t              dsel_reg, dsel_next;

    assign drem_sh = {drem_reg, dq_reg[W-1]};
    assign dge     = (drem_sh >= {1'b0, dsor_reg});

    always_comb
    begin
        dq_next   = dq_reg;
        drem_next = drem_reg;
        dsor_next = dsor_reg;
        dneg_next = dneg_reg;
        dcnt_next = dcnt_reg;
        dsel_next = dsel_reg;
        if (cmd.div_start)
        begin
            dq_next   = div_dvd;
            drem_next = '0;
            dsor_next = div_dsor;
            dneg_next = div_neg;
            dcnt_next = lrc_pkg::DIV_CNT_W'(W);
            dsel_next = cmd.div_sel;
        end
        else if (dcnt_reg != '0)
        begin
            drem_next = dge ? W'(drem_sh - {1'b0, dsor_reg}) : W'(drem_sh);
            dq_next   = {dq_reg[W-2:0], dge};
            dcnt_next = dcnt_reg - lrc_pkg::DIV_CNT_W'(1);
        end
    end

    // saturate the quotient into the result formats
    logic [QW-1:0] q_sat;
    logic [CW-1:0] corr_mag, corr_sat;
    always_comb
    begin
        if (dneg_reg)
        begin
            q_sat = (dq_reg > Q_NEG_MAG) ? Q_MIN : -dq_reg[QW-1:0];
        end
        else
        begin
            q_sat = (dq_reg > Q_POS_MAX) ? Q_MAX : dq_reg[QW-1:0];
        end
        corr_mag = (dq_reg > CORR_ONE) ? CORR_ONE[CW-1:0] : dq_reg[CW-1:0];
        corr_sat = dneg_reg ? -corr_mag : corr_mag;
    end

    // result fields of the data set
    logic signed [QW-1:0] icpt_reg, icpt_next, slope_reg, slope_next;
    logic signed [CW-1:0] corr_reg, corr_next;
    logic                 degen_reg, degen_next, undef_reg, undef_next;

    always_comb
    begin
        icpt_next  = icpt_reg;
        slope_next = slope_reg;
        corr_next  = corr_reg;
        degen_next = degen_reg;
        undef_next = undef_reg;
        if (cmd.res_clear)
        begin
            icpt_next  = '0;
            slope_next = '0;
            corr_next  = '0;
            degen_next = 1'b0;
            undef_next = 1'b0;
        end
        else
        begin
            if (cmd.set_degen)
            begin
                degen_next = 1'b1;
            end
            if (cmd.set_undef)
            begin
                undef_next = 1'b1;
            end
            if (cmd.div_commit)
            begin
                unique case (dsel_reg)
                    lrc_pkg::DIV_INTERCEPT: icpt_next  = q_sat;
                    lrc_pkg::DIV_SLOPE:     slope_next = q_sat;
                    lrc_pkg::DIV_CORR:      corr_next  = corr_sat;
                    default:                corr_next  = corr_reg;
                endcase
            end
        end
    end

    // output register
    lrc_pkg::result_t out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_next.intercept      = icpt_reg;
            out_next.slope          = slope_reg;
            out_next.correlation    = corr_reg;
            out_next.degenerate     = degen_reg;
            out_next.corr_undefined = undef_reg;
            out_valid_next          = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg     <= 1'b0;
            rcnt_reg      <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mbusy_reg     <= mbusy_next;
            rcnt_reg      <= rcnt_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        tmp_reg   <= tmp_next;
        det_reg   <= det_next;
        bnum_reg  <= bnum_next;
        anum_reg  <= anum_next;
        vy_reg    <= vy_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        prod_reg  <= prod_next;
        mneg_reg  <= mneg_next;
        msel_reg  <= msel_next;
        rsrc_reg  <= rsrc_next;
        rrem_reg  <= rrem_next;
        root_reg  <= root_next;
        dq_reg    <= dq_next;
        drem_reg  <= drem_next;
        dsor_reg  <= dsor_next;
        dneg_reg  <= dneg_next;
        dsel_reg  <= dsel_next;
        icpt_reg  <= icpt_next;
        slope_reg <= slope_next;
        corr_reg  <= corr_next;
        degen_reg <= degen_next;
        undef_reg <= undef_next;
        out_reg   <= out_next;
    end

    // status back to the controller
    assign status.mul_busy  = mbusy_reg;
    assign status.div_busy  = (dcnt_reg != '0);
    assign status.root_busy = (rcnt_reg != '0);
    assign status.det_zero  = (det_reg == '0);
    assign status.vy_zero   = (vy_reg == '0);
    assign status.root_zero = (root_reg == '0);
    assign status.out_free  = !out_valid_reg || result_ready;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

FILE: design/lrc_ctrl.sv
// controller: accumulation, then the multiply, divide and root sequence of a data set
`timescale 1ns / 1ps

module lrc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    input  logic             sample_last,
    output logic             sample_ready,
    input  lrc_pkg::status_t status,
    output lrc_pkg::cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_ACC        = 8'b0000_0001,
        ST_MUL_ISSUE  = 8'b0000_0010,
        ST_MUL_WAIT   = 8'b0000_0100,
        ST_DIV_ISSUE  = 8'b0000_1000,
        ST_DIV_WAIT   = 8'b0001_0000,
        ST_ROOT_ISSUE = 8'b0010_0000,
        ST_ROOT_WAIT  = 8'b0100_0000,
        ST_RESULT     = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    lrc_pkg::mul_op_t mix_reg, mix_next;
    lrc_pkg::div_op_t dix_reg, dix_next;

    // sequencing
    always_comb
    begin
        state_next   = state_reg;
        mix_next     = mix_reg;
        dix_next     = dix_reg;
        sample_ready = 1'b0;
        cmd          = '0;
        cmd.mul_sel  = mix_reg;
        cmd.div_sel  = dix_reg;
        unique case (state_reg)
            ST_ACC:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.acc_en = 1'b1;
                    if (sample_last)
                    begin
                        cmd.res_clear = 1'b1;
                        mix_next      = lrc_pkg::MUL_N_SXX;
                        state_next    = ST_MUL_ISSUE;
                    end
                end
            end
            ST_MUL_ISSUE:
            begin
                // determinant is known once its pair is stored
                if (mix_reg == lrc_pkg::MUL_SXX_SY && status.det_zero)
                begin
                    cmd.set_degen = 1'b1;
                    state_next    = ST_RESULT;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_MUL_WAIT;
                end
            end
            ST_MUL_WAIT:
            begin
                if (!status.mul_busy)
                begin
                    cmd.mul_commit = 1'b1;
                    priority if (mix_reg == lrc_pkg::MUL_SY_SY)
                    begin
                        dix_next   = lrc_pkg::DIV_INTERCEPT;
                        state_next = ST_DIV_ISSUE;
                    end
                    else if (mix_reg == lrc_pkg::MUL_DET_VY)
                    begin
                        state_next = ST_ROOT_ISSUE;
                    end
                    else
                    begin
                        mix_next   = lrc_pkg::mul_op_t'(mix_reg + 4'd1);
                        state_next = ST_MUL_ISSUE;
                    end
                end
            end
            ST_DIV_ISSUE:
            begin
                if (dix_reg == lrc_pkg::DIV_CORR && status.root_zero)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.div_commit = 1'b1;
                    unique case (dix_reg)
                        lrc_pkg::DIV_INTERCEPT:
                        begin
                            dix_next   = lrc_pkg::DIV_SLOPE;
                            state_next = ST_DIV_ISSUE;
                        end
                        lrc_pkg::DIV_SLOPE:
                        begin
                            if (status.vy_zero)
                            begin
                                cmd.set_undef = 1'b1;
                                state_next    = ST_RESULT;
                            end
                            else
                            begin
                                mix_next   = lrc_pkg::MUL_DET_VY;
                                state_next = ST_MUL_ISSUE;
                            end
                        end
                        lrc_pkg::DIV_CORR:
                        begin
                            state_next = ST_RESULT;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_ROOT_ISSUE:
            begin
                cmd.root_start = 1'b1;
                state_next     = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT:
            begin
                if (!status.root_busy)
                begin
                    dix_next   = lrc_pkg::DIV_CORR;
                    state_next = ST_DIV_ISSUE;
                end
            end
            ST_RESULT:
            begin
                // hand over the result and start a fresh data set
                if (status.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.acc_clear = 1'b1;
                    state_next    = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            mix_reg   <= lrc_pkg::MUL_N_SXX;
            dix_reg   <= lrc_pkg::DIV_INTERCEPT;
        end
        else
        begin
            state_reg <= state_next;
            mix_reg   <= mix_next;
            dix_reg   <= dix_next;
        end
    end

endmodule

FILE: design/linear_regression_correlation.sv
// Streaming least-squares line fit with Pearson correlation. While a data set
// is being collected the block takes one (x, y) item per cycle into running
// sums. The item marked last is added too, then the block stops taking items
// and works out intercept and slope (signed Q31.16, truncated toward zero,
// saturated) and the correlation (Q1.14) on one shift-add multiplier, one
// restoring divider and one square-root unit, all working a bit or a bit pair
// a cycle: nine multiplications, each ending when its second operand runs out
// of bits, three divisions and one root, fewer for a degenerate set. A result
// item waiting in the output register does not stop a new data set from being
// collected, but the next result waits until it has been taken.
`timescale 1ns / 1ps
`include "linear_regression_correlation_macros.svh"

module linear_regression_correlation (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_ready,
    input  lrc_pkg::sample_t sample,
    output logic             result_valid,
    input  logic             result_ready,
    output lrc_pkg::result_t result
);

    lrc_pkg::cmd_t    cmd;
    lrc_pkg::status_t status;

    // sequencer
    lrc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_last  (sample.last),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    // sums and arithmetic units
    lrc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // checks
    `LRC_ASSERT_IMP(a_degen_zero, result_valid && result.degenerate,
        result.intercept == '0 && result.slope == '0 && result.correlation == '0
        && !result.corr_undefined, "degenerate item with nonzero fields")
    `LRC_ASSERT_IMP(a_undef_zero, result_valid && result.corr_undefined,
        result.correlation == '0, "undefined correlation is not zero")
    `LRC_ASSERT_IMP(a_corr_range, result_valid,
        result.correlation <= 16'sd16384 && result.correlation >= -16'sd16384,
        "correlation out of range")
    `LRC_ASSERT_NXT(a_busy_after_last, sample_valid && sample_ready && sample.last,
        !sample_ready, "item taken while a data set is being solved")

endmodule
